FILE: src/pcsf_pkg.sv
// Shared types and constants for the pump controller with slope filter.
`timescale 1ns / 1ps

package pcsf_pkg;

   localparam int NUM_TAPS   = 8;
   localparam int NUM_PAIRS  = NUM_TAPS / 2;
   localparam int DEF_WARMUP = 8;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 6;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PROD_W   = DIFF_W + COEF_W + 1;
   localparam int TERM_W   = PROD_W - 3;
   localparam int SUM_W    = TERM_W + 2;
   localparam int RUN_W    = 32;
   localparam int MAXDIF_W = 17;

   localparam logic [COEF_W-1:0] SLOPE_COEF [NUM_PAIRS] = '{6'd8, 6'd14, 6'd24, 6'd40};

   localparam logic [RUN_W-1:0] RST_MIN_RUN = 32'd60000;
   localparam logic [RUN_W-1:0] RST_MAX_RUN = 32'd600000;

   typedef enum logic [1:0] {
      OP_HEATER = 2'd0,
      OP_MIXER  = 2'd1,
      OP_RETURN = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_MIN_RUN   = 2'd1,
      CSR_MAX_RUN   = 2'd2,
      CSR_MAX_DIFF  = 2'd3
   } csr_index_type;

endpackage

FILE: src/pump_control_with_slope_filter.sv
// Top level: pump controller driven by a slope filter over heater samples.
// Each word is accepted, applied to the sample shift line,
// the four-pair slope filter and the pump rule, and its result is registered at
// the same edge, so words may follow back to back while rsp_tready is high. The path from a heater
// sample through the pair multipliers, the saturating sum and the threshold
// compare sets the clock. A new word is taken while the result register is
// empty or being read; a result is held until rsp_tready.
`timescale 1ns / 1ps

module pump_control_with_slope_filter
   import pcsf_pkg::*;
#(
   parameter int WARMUP = DEF_WARMUP
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] pump_on, [1] pump_changed, [17:2] filtered, zeros
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [7:0] WARMUP_INIT = 8'(WARMUP);

   logic signed [SAMPLE_W-1:0] thresh_ff;
   logic        [RUN_W-1:0]    min_run_ff;
   logic        [RUN_W-1:0]    max_run_ff;
   logic signed [MAXDIF_W-1:0] max_diff_ff;

   logic        [7:0]          warmup_ff,   warmup_in;
   logic signed [SAMPLE_W-1:0] filter_ff,   filter_in;
   logic                       pump_ff,     pump_in;
   logic        [RUN_W-1:0]    run_ff,      run_in;
   logic signed [SAMPLE_W-1:0] mixer_ff,    mixer_in;
   logic signed [SAMPLE_W-1:0] return_ff,   return_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_on_ff;
   logic                       rsp_chg_ff;
   logic signed [SAMPLE_W-1:0] rsp_filt_ff;

   logic                       fire;
   logic                       shift;
   op_type                     op;
   logic signed [SAMPLE_W-1:0] value;
   logic signed [SAMPLE_W-1:0] chain [NUM_TAPS];
   logic signed [TERM_W-1:0]   term  [NUM_PAIRS];
   logic signed [SUM_W-1:0]    sum;
   logic signed [SUM_W-1:0]    sat_hi;
   logic signed [SUM_W-1:0]    sat_lo;
   logic signed [SAMPLE_W-1:0] filter_sat;
   logic        [RUN_W-1:0]    run_tick;
   logic signed [DIFF_W-1:0]   temp_diff;
   logic                       start;
   logic                       stop;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign value      = req_tdata;
   assign shift      = fire && (op == OP_HEATER);
   assign csr_ready  = 1'b1;

   // sample shift line: cell 0 holds the newest sample, the last cell the oldest
   assign chain[0] = value;

   for (genvar k = 0; k < NUM_TAPS-1; k++) begin : g_cell
      pcsf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .sample_in  (chain[k]),
         .sample_out (chain[k+1])
      );
   end

   for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
      pcsf_pair u_pair (
         .newer (chain[p]),
         .older (chain[NUM_TAPS-1-p]),
         .coef  (SLOPE_COEF[p]),
         .term  (term[p])
      );
   end

   always_comb begin
      sum = '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         sum = sum + {{(SUM_W-TERM_W){term[p][TERM_W-1]}}, term[p]};
      end
      sat_hi = {{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
      sat_lo = {{(SUM_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
      if (sum > sat_hi) begin
         filter_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (sum < sat_lo) begin
         filter_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         filter_sat = sum[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      warmup_in = warmup_ff;
      filter_in = filter_ff;
      mixer_in  = mixer_ff;
      return_in = return_ff;
      run_tick  = run_ff;
      if (fire) begin
         case (op)
            OP_HEATER: begin
               if (warmup_ff != '0) begin
                  warmup_in = warmup_ff - 8'd1;
               end else begin
                  filter_in = filter_sat;
               end
            end
            OP_MIXER:  mixer_in  = value;
            OP_RETURN: return_in = value;
            OP_TICK: begin
               if (run_ff != '1) begin
                  run_tick = run_ff + 32'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      temp_diff = {mixer_in[SAMPLE_W-1], mixer_in} - {return_in[SAMPLE_W-1], return_in};
      stop  = fire && pump_ff && (run_tick > min_run_ff)
              && ((temp_diff < max_diff_ff) || (run_tick > max_run_ff));
      start = fire && !pump_ff && (filter_in > thresh_ff);
      pump_in = pump_ff;
      if (start) begin
         pump_in = 1'b1;
      end else if (stop) begin
         pump_in = 1'b0;
      end
      run_in = start ? '0 : run_tick;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= '0;
         min_run_ff   <= RST_MIN_RUN;
         max_run_ff   <= RST_MAX_RUN;
         max_diff_ff  <= '0;
         warmup_ff    <= WARMUP_INIT;
         filter_ff    <= '0;
         pump_ff      <= 1'b0;
         run_ff       <= '0;
         mixer_ff     <= '0;
         return_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD: thresh_ff   <= csr_data[SAMPLE_W-1:0];
               CSR_MIN_RUN:   min_run_ff  <= csr_data[RUN_W-1:0];
               CSR_MAX_RUN:   max_run_ff  <= csr_data[RUN_W-1:0];
               CSR_MAX_DIFF:  max_diff_ff <= csr_data[MAXDIF_W-1:0];
               default: ;
            endcase
         end
         warmup_ff    <= warmup_in;
         filter_ff    <= filter_in;
         pump_ff      <= pump_in;
         run_ff       <= run_in;
         mixer_ff     <= mixer_in;
         return_ff    <= return_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_on_ff   <= pump_in;
         rsp_chg_ff  <= start || stop;
         rsp_filt_ff <= filter_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_filt_ff, rsp_chg_ff, rsp_on_ff};

   a_start_clears_run: assert property (@(posedge clock) disable iff (reset)
      start |=> run_ff == '0)
      else $error("run time not cleared on pump start");

   a_filter_hold: assert property (@(posedge clock) disable iff (reset)
      !shift |=> $stable(filter_ff))
      else $error("filter value changed without a heater sample");

   a_warmup_down: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> warmup_ff <= $past(warmup_ff))
      else $error("warm-up count increased");

   a_run_saturate: assert property (@(posedge clock) disable iff (reset)
      (run_ff == '1) && !start |=> run_ff == '1)
      else $error("run time wrapped");

   a_rsp_matches_pump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_on_ff == pump_ff)
      else $error("pending result disagrees with pump state");

endmodule

FILE: src/pcsf_cell.sv
// One sample cell of the heater history shift line.
`timescale 1ns / 1ps

module pcsf_cell
   import pcsf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] sample_in_w;

   always_comb begin
      sample_in_w = shift ? sample_in : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_w;
      end
   end

   assign sample_out = sample_ff;

endmodule

FILE: src/pcsf_pair.sv
// Weighted difference of one mirrored tap pair, floored by eight.
`timescale 1ns / 1ps

module pcsf_pair
   import pcsf_pkg::*;
(
   input  logic signed [SAMPLE_W-1:0] newer,
   input  logic signed [SAMPLE_W-1:0] older,
   input  logic        [COEF_W-1:0]   coef,
   output logic signed [TERM_W-1:0]   term
);

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [COEF_W:0]   coef_s;

   always_comb begin
      diff   = {newer[SAMPLE_W-1], newer} - {older[SAMPLE_W-1], older};
      coef_s = {1'b0, coef};
      prod   = {{(COEF_W+1){diff[DIFF_W-1]}}, diff} * {{DIFF_W{1'b0}}, coef_s};
      term   = prod[PROD_W-1:3];
   end

endmodule
